### rtl/itra_pkg.sv
package itra_pkg;

  // Width of the signed value to convert.
  localparam int VALUE_BITS = 32;

  // Digit counter holds 0..VALUE_BITS; the digit store index holds 0..VALUE_BITS-1.
  localparam int COUNT_W = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W  = $clog2(VALUE_BITS);

  // The divider retires DIV_STEP quotient bits per clock cycle while it steps.
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_BITS   = DIV_CYCLES * DIV_STEP;
  localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Radix and digit encoding.
  localparam int BASE_W    = 6;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 8;
  localparam logic [BASE_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [BASE_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [BASE_W-1:0] RADIX_DEFAULT = 6'd10;
  localparam logic [CHAR_W-1:0] MINUS_CHAR    = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
  // 'a' minus ten, so that digit ten maps to 'a'.
  localparam logic [CHAR_W-1:0] CHAR_ALPHA    = 8'h57;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new request
    logic step;        // one divider iteration
    logic store;       // write the remainder digit and count it
    logic emit_sign;   // present the minus sign
    logic read;        // fetch the next digit from the store
    logic emit_digit;  // present the fetched digit
  } itra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic negative;    // the request value is negative
    logic q_zero;      // quotient left after this digit is zero
    logic count_full;  // this digit is the last that fits the store
    logic count_one;   // one digit left to emit
  } itra_status_t;

  // Digit value to its lowercase ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < DECIMAL_DIGITS) begin
      digit_char = CHAR_ZERO + ext;
    end else begin
      digit_char = CHAR_ALPHA + ext;
    end
  endfunction

endpackage

### rtl/itra_ram.sv
module itra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/itra_ctrl.sv
module itra_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  itra_pkg::itra_status_t status,
  output itra_pkg::itra_cmd_t    cmd
);
  import itra_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] step_cnt_next;
  logic              div_last;

  assign div_last = (step_cnt == STEP_W'(DIV_CYCLES - 1));
  assign busy     = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          step_cnt_next = '0;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (div_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store     = 1'b1;
        step_cnt_next = '0;
        if (status.q_zero || status.count_full) begin
          state_next = status.negative ? S_SIGN : S_READ;
        end else begin
          state_next = S_DIV;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        state_next     = status.count_one ? S_IDLE : S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // A digit is stored only after a full division pass.
  a_store_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_STORE) |-> ($past(state) == S_DIV))
    else $error("digit stored without a preceding division");

  // Every emitted digit was fetched in the cycle before.
  a_emit_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ($past(state) == S_READ))
    else $error("digit emitted without a store read");

endmodule

### rtl/itra_dp.sv
module itra_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [itra_pkg::VALUE_BITS-1:0]   value,
  input  logic [itra_pkg::BASE_W-1:0]       base,
  input  itra_pkg::itra_cmd_t               cmd,
  output itra_pkg::itra_status_t            status,
  output logic                              strobe,
  output logic [itra_pkg::CHAR_W-1:0]       character,
  output logic                              last
);
  import itra_pkg::*;

  logic [BASE_W-1:0]     radix;
  logic                  negative;
  logic [DIV_BITS-1:0]   quot;
  logic [DIGIT_W-1:0]    rem;
  logic [COUNT_W-1:0]    count;
  logic [DIV_BITS-1:0]   quot_next;
  logic [DIGIT_W-1:0]    rem_next;
  logic [VALUE_BITS-1:0] magnitude;
  logic                  base_ok;
  logic [DIGIT_W-1:0]    rd_digit;
  logic [ADDR_W-1:0]     rd_addr;
  logic [COUNT_W-1:0]    count_dec;

  // Radix selection and magnitude of the request value.
  assign base_ok   = (base >= RADIX_MIN) && (base <= RADIX_MAX);
  assign magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

  // Restoring division by the radix, DIV_STEP quotient bits per cycle while cmd.step is high.
  always_comb begin
    logic [DIGIT_W:0] part;
    logic [DIGIT_W:0] div_ext;
    quot_next = quot;
    rem_next  = rem;
    div_ext   = {1'b0, radix};
    for (int i = 0; i < DIV_STEP; i++) begin
      part      = {rem_next, quot_next[DIV_BITS-1]};
      quot_next = {quot_next[DIV_BITS-2:0], 1'b0};
      if (part >= div_ext) begin
        rem_next     = DIGIT_W'(part - div_ext);
        quot_next[0] = 1'b1;
      end else begin
        rem_next = part[DIGIT_W-1:0];
      end
    end
  end

  // Status for the controller.
  assign status.negative   = negative;
  assign status.q_zero     = (quot == '0);
  assign status.count_full = (count == COUNT_W'(VALUE_BITS - 1));
  assign status.count_one  = (count == COUNT_W'(1));

  assign count_dec = count - 1'b1;
  assign rd_addr   = count_dec[ADDR_W-1:0];

  // Digit store, least significant digit first.
  itra_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count[ADDR_W-1:0]),
    .wdata (rem),
    .raddr (rd_addr),
    .rdata (rd_digit)
  );

  // Conversion registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      quot     <= '0;
      negative <= 1'b0;
    end else begin
      if (cmd.load) begin
        radix    <= base_ok ? base : RADIX_DEFAULT;
        negative <= value[VALUE_BITS-1];
        quot     <= DIV_BITS'(magnitude);
        rem      <= '0;
        count    <= '0;
      end
      if (cmd.step) begin
        quot <= quot_next;
        rem  <= rem_next;
      end
      if (cmd.store) begin
        count <= count + 1'b1;
        rem   <= '0;
      end
      if (cmd.emit_digit) begin
        count <= count_dec;
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign || cmd.emit_digit;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= MINUS_CHAR;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= digit_char(rd_digit);
      last      <= status.count_one;
    end
  end

  // The store never overflows.
  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (count < COUNT_W'(VALUE_BITS)))
    else $error("digit store written beyond its depth");

  // A digit is never read from an empty store.
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.read || cmd.emit_digit) |-> (count != '0))
    else $error("digit read with no digits held");

endmodule

### rtl/int_to_radix_ascii_top.sv
// Signed integer to ASCII text. A request (start high while busy is low) takes a
// VALUE_BITS-bit two's complement value and a radix; a radix outside 2..36 means 10.
// The text comes out most significant character first, with '-' ahead of a negative
// value, one character per strobe, and last marks the final character. Results are
// not held: each is on character/last for exactly the one cycle that strobe is high,
// so the receiver must take it then. For each digit the shared divider first runs its
// division steps, retiring eight quotient bits a cycle while it steps, and the store
// is then written with the digit. After the last digit the '-' is presented if the
// value is negative, and then each digit is read from the store and output. The last
// strobe comes in the first cycle that busy is low again; the longest text is the 32
// binary digits of a negative value, after its '-'.
module int_to_radix_ascii_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [itra_pkg::VALUE_BITS-1:0] value,
  input  logic [itra_pkg::BASE_W-1:0]     base,
  output logic                            strobe,
  output logic [itra_pkg::CHAR_W-1:0]     character,
  output logic                            last
);
  import itra_pkg::*;

  itra_cmd_t    cmd;
  itra_status_t status;
  logic         req;

  assign req = start && !busy;

  // Sequencer.
  itra_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Divider, digit store and output registers.
  itra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .base      (base),
    .cmd       (cmd),
    .status    (status),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  // A result only ever follows a busy cycle.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without a conversion in progress");

  // The final character closes the text: no result follows straight after it.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("result strobe right after the final character");

  // A request is taken only into an idle block and makes it busy.
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req |=> busy)
    else $error("request accepted but block not busy");

endmodule

### tb/int_to_radix_ascii_top_tb.sv
module int_to_radix_ascii_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itra_pkg::*;

  // Cycles with neither a request taken nor a character emitted before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles after the last character, to catch stray strobes.
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } text_char_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [VALUE_BITS-1:0] value = '0;
  logic [BASE_W-1:0]     base = '0;
  logic                  strobe;
  logic [CHAR_W-1:0]     character;
  logic                  last;

  text_char_t pending_chars[$];
  int         error_count = 0;
  int         idle_pct = 0;
  int         quiet_cycles = 0;

  int_to_radix_ascii_top DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .base      (base),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Works out the text of one request and queues its characters, most significant first.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] v,
                                       input logic [BASE_W-1:0] b);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] radix;
    logic [VALUE_BITS-1:0] rem;
    logic [DIGIT_W-1:0]    digits[VALUE_BITS];
    int                    n;
    text_char_t            c;
    radix = (b < RADIX_MIN || b > RADIX_MAX) ? VALUE_BITS'(RADIX_DEFAULT) : VALUE_BITS'(b);
    // The magnitude is taken as unsigned, so the most negative value needs no special care.
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    n = 0;
    do begin
      rem = mag % radix;
      digits[n] = rem[DIGIT_W-1:0];
      mag = mag / radix;
      n++;
    end while (mag != 0 && n < VALUE_BITS);
    if (v[VALUE_BITS-1]) begin
      c.ch = MINUS_CHAR;
      c.fin = 1'b0;
      pending_chars.push_back(c);
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] < 10) begin
        c.ch = 8'("0") + CHAR_W'(digits[k]);
      end else begin
        c.ch = 8'("a") + CHAR_W'(digits[k]) - 8'd10;
      end
      c.fin = (k == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // Offers one request, idling at random, and queues its text once it is taken.
  task automatic send_request(input logic [VALUE_BITS-1:0] v, input logic [BASE_W-1:0] b);
    bit taken;
    taken = 1'b0;
    @(negedge clk);
    value = v;
    base = b;
    while (!taken) begin
      start = ($urandom_range(99) >= idle_pct);
      @(posedge clk);
      if (start && !busy) begin
        taken = 1'b1;
      end else begin
        @(negedge clk);
      end
    end
    predict_text(v, b);
  endtask

  // Values weighted toward the interesting corners: tiny, powers of two and the extremes.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom();
      1: v = VALUE_BITS'($urandom_range(1000));
      2: v = (VALUE_BITS'(1) << $urandom_range(VALUE_BITS - 1)) - VALUE_BITS'($urandom_range(1));
      default: begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = {1'b1, {(VALUE_BITS - 1){1'b0}}};
          2: v = {1'b0, {(VALUE_BITS - 1){1'b1}}};
          default: v = '1;
        endcase
      end
    endcase
    // Flip the sign of about half of the picks so that both halves of the range are well covered.
    if ($urandom_range(1)) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  // Mostly legal radices; the rest spans the whole field, out-of-range values included.
  function automatic logic [BASE_W-1:0] pick_base();
    if ($urandom_range(99) < 85) begin
      return BASE_W'($urandom_range(RADIX_MAX, RADIX_MIN));
    end
    return BASE_W'($urandom_range(63));
  endfunction

  task automatic run_random_requests(input int count);
    repeat (count) begin
      send_request(pick_value(), pick_base());
    end
  endtask

  // Field extremes, every out-of-range radix class, zero and the most negative value.
  task automatic test_directed_cases();
    idle_pct = 0;
    send_request(32'd0, 6'd10);
    send_request(32'd0, 6'd2);
    send_request(32'd1, 6'd10);
    send_request(-32'sd1, 6'd10);
    send_request(32'h7fff_ffff, 6'd10);
    send_request(32'h8000_0000, 6'd10);
    send_request(32'h8000_0000, 6'd2);
    send_request(32'h7fff_ffff, 6'd2);
    send_request(-32'sd1, 6'd2);
    send_request(32'h8000_0000, 6'd36);
    send_request(32'd35, 6'd36);
    send_request(-32'sd36, 6'd36);
    send_request(32'hdead_beef, 6'd16);
    send_request(32'd255, 6'd16);
    send_request(32'd12345, 6'd0);
    send_request(-32'sd12345, 6'd1);
    send_request(32'd987654, 6'd37);
    send_request(-32'sd42, 6'd63);
    send_request(32'd80, 6'd3);
    send_request(-32'sd1295, 6'd36);
    send_request(32'd1000, 6'd35);
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    run_random_requests(60);
  endtask

  task automatic test_sparse_requests();
    idle_pct = 78;
    run_random_requests(60);
  endtask

  task automatic test_light_gaps();
    idle_pct = 7;
    run_random_requests(60);
  endtask

  // Each strobed character is compared with the oldest one still owed.
  always @(posedge clk) begin : check_results
    text_char_t want;
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, character, last);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (character !== want.ch) begin
          $display("%0t: character expected %h actual %h", $time, want.ch, character);
          error_count++;
        end
        if (last !== want.fin) begin
          $display("%0t: last expected %b actual %b", $time, want.fin, last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on progress: any taken request or emitted character restarts the count.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_back_to_back();
    test_sparse_requests();
    test_light_gaps();
    @(negedge clk);
    start = 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
